// ===== sv/nsqrt_pkg.sv =====
// ----------------------------------------------------------------------------
// nsqrt_pkg - shared constants and types
// Fixed-point formats, step cap and controller states for the Newton square
// root block.
// ----------------------------------------------------------------------------
`default_nettype none

package nsqrt_pkg;

    localparam int INPUT_BITS    = 20;
    localparam int FRACTION_BITS = 32;
    localparam int MAX_STEPS     = 64;
    localparam int VALUE_BITS    = INPUT_BITS + FRACTION_BITS;

    // numerator x << 2F, fed into the divider one bit per cycle
    localparam int NUM_BITS = INPUT_BITS + 2 * FRACTION_BITS;
    localparam int DIV_CW   = $clog2(NUM_BITS);
    localparam int SQR_CW   = $clog2(VALUE_BITS);
    localparam int STEP_W   = $clog2(MAX_STEPS + 1);

    // residual: (y*y >> F) - (x << F), signed
    localparam int DIFF_W = 2 * VALUE_BITS - FRACTION_BITS + 1;

    localparam logic [VALUE_BITS-1:0] TWO_POINT_ZERO =
        VALUE_BITS'(1) << (FRACTION_BITS + 1);
    localparam logic [31:0] TOL_RESET = 32'd429497;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_DIV,
        S_SQR,
        S_CHK,
        S_END
    } t_state;

endpackage

`default_nettype wire

// ===== sv/nsqrt_div.sv =====
// ----------------------------------------------------------------------------
// nsqrt_div - bit-serial restoring divider
// Computes floor((num << 2F) / den), one quotient bit per cycle, saturated
// to the value width.
// ----------------------------------------------------------------------------
`default_nettype none

module nsqrt_div
    import nsqrt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [INPUT_BITS-1:0] i_num,
    input  wire logic [VALUE_BITS-1:0] i_den,
    output logic                       o_done,
    output logic [VALUE_BITS-1:0]      o_quot
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CW-1:0]     r_cnt;
    logic [INPUT_BITS-1:0] r_num;
    logic [VALUE_BITS-1:0] r_den;
    logic [VALUE_BITS-1:0] r_rem;
    logic [VALUE_BITS-1:0] r_quot;
    logic                  r_ovf;

    logic [VALUE_BITS:0]   w_sh;
    logic [VALUE_BITS+1:0] w_sub;
    logic                  w_ge;

    // partial remainder stays below den, so one extra bit holds the shift
    assign w_sh  = {r_rem, r_num[INPUT_BITS-1]};
    assign w_sub = {1'b0, w_sh} - {2'b00, r_den};
    assign w_ge  = ~w_sub[VALUE_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_CW'(NUM_BITS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= '0;
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + DIV_CW'(1);
            r_num  <= {r_num[INPUT_BITS-2:0], 1'b0};
            r_rem  <= w_ge ? w_sub[VALUE_BITS-1:0] : w_sh[VALUE_BITS-1:0];
            r_quot <= {r_quot[VALUE_BITS-2:0], w_ge};
            // any bit pushed out of the top means the quotient saturates
            r_ovf  <= r_ovf | r_quot[VALUE_BITS-1];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_ovf ? {VALUE_BITS{1'b1}} : r_quot;

endmodule

`default_nettype wire

// ===== sv/nsqrt_sqr.sv =====
// ----------------------------------------------------------------------------
// nsqrt_sqr - bit-serial squarer
// Shift-and-add multiplier producing y*y, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nsqrt_sqr
    import nsqrt_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [VALUE_BITS-1:0]   i_y,
    output logic                         o_done,
    output logic [2*VALUE_BITS-1:0]      o_prod
);

    logic                  r_busy;
    logic                  r_done;
    logic [SQR_CW-1:0]     r_cnt;
    logic [VALUE_BITS-1:0] r_m;
    logic [VALUE_BITS-1:0] r_hi;
    logic [VALUE_BITS-1:0] r_lo;
    logic [VALUE_BITS:0]   w_sum;

    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_m} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == SQR_CW'(VALUE_BITS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_m   <= i_y;
            r_hi  <= '0;
            r_lo  <= i_y;
        end else if (r_busy) begin
            r_cnt <= r_cnt + SQR_CW'(1);
            r_hi  <= w_sum[VALUE_BITS:1];
            r_lo  <= {w_sum[0], r_lo[VALUE_BITS-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

`default_nettype wire

// ===== sv/newton_square_root_warm_start.sv =====
// ----------------------------------------------------------------------------
// newton_square_root_warm_start - Newton square root, warm-started
// Iterates y = (x/g + g)/2 in 20.32 fixed point until |x - y*y| < tolerance
// or the step cap is hit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one radicand per beat; output
//   channel (o_valid/i_ready) returns root, converged flag and step count.
//   i_cfg_wr_en/i_cfg_wr_data write the tolerance; write only while idle.
// Sequencing:
//   One item at a time. Each Newton step runs a set-up state, then the
//   bit-serial divider, one quotient bit per cycle over 84 numerator bits,
//   then the bit-serial squarer, one bit per cycle over 52 bits, then the
//   residual-check states S_CHK and S_END.
//   An item runs from 1 to MAX_STEPS steps.
//   A warm guess close to the root typically needs one to three steps.
// Reset:
//   Synchronous, active low. Tolerance returns to 429497 (about 1e-4),
//   the kept guess to 2.0, the output register empties.
// Back-pressure:
//   The result sits in an output register; a new radicand is taken while it
//   waits. If the next result is ready before the old one is taken, the
//   block holds in its final state until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module newton_square_root_warm_start
    import nsqrt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [31:0]           i_cfg_wr_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [INPUT_BITS-1:0] i_radicand,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [VALUE_BITS-1:0]      o_root,
    output logic                       o_converged,
    output logic [6:0]                 o_steps_taken
);

    t_state r_state, n_state;

    logic [31:0]           r_tol;
    logic [VALUE_BITS-1:0] r_guess;   // kept guess, carried between items
    logic [VALUE_BITS-1:0] r_gstep;   // guess used by the running step
    logic [INPUT_BITS-1:0] r_x;
    logic [STEP_W-1:0]     r_steps;
    logic [DIFF_W-1:0]     r_diff;
    logic                  r_ok;

    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_root;
    logic                  r_out_conv;
    logic [STEP_W-1:0]     r_out_steps;

    logic                    div_start, div_done;
    logic [VALUE_BITS-1:0]   div_quot;
    logic [VALUE_BITS-1:0]   step_den;
    logic                    sqr_start, sqr_done;
    logic [2*VALUE_BITS-1:0] sqr_prod;
    logic                    out_load;
    logic                    cap_hit;

    logic [VALUE_BITS-1:0] w_y;
    logic [DIFF_W-1:0]     w_diff;
    logic [DIFF_W-1:0]     w_sum;
    logic                  w_ok;

    // a zero guess is replaced by 2.0 before every step
    assign step_den = (r_guess == '0) ? TWO_POINT_ZERO : r_guess;

    // new estimate: q/2 + g/2, plus one when both are odd
    assign w_y = (div_quot >> 1) + (r_gstep >> 1)
               + VALUE_BITS'(div_quot[0] & r_gstep[0]);

    // (y*y truncated to F fraction bits) - (x << F)
    assign w_diff = {1'b0, sqr_prod[2*VALUE_BITS-1:FRACTION_BITS]}
                  - DIFF_W'({r_x, {FRACTION_BITS{1'b0}}});

    // |d| < tol: d >= 0 needs d < tol, d < 0 needs d + tol > 0
    assign w_sum = r_diff + DIFF_W'(r_tol);
    assign w_ok  = r_diff[DIFF_W-1] ? (!w_sum[DIFF_W-1] && w_sum != '0)
                                    : (r_diff < DIFF_W'(r_tol));

    assign cap_hit = (r_steps == STEP_W'(MAX_STEPS));

    nsqrt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_x),
        .i_den   (step_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    nsqrt_sqr u_sqr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqr_start),
        .i_y     (w_y),
        .o_done  (sqr_done),
        .o_prod  (sqr_prod)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        sqr_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    sqr_start = 1'b1;
                    n_state   = S_SQR;
                end
            end
            S_SQR: begin
                if (sqr_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = S_END;
            end
            S_END: begin
                if (r_ok || cap_hit) begin
                    if (!r_out_valid || i_ready) begin
                        out_load = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_state = S_STEP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_tol       <= TOL_RESET;
            r_guess     <= TWO_POINT_ZERO;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_tol <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_DIV && div_done) begin
                r_guess <= w_y;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_x     <= i_radicand;
            r_steps <= '0;
        end
        if (r_state == S_STEP) begin
            r_gstep <= step_den;
        end
        if (r_state == S_DIV && div_done) begin
            r_steps <= r_steps + STEP_W'(1);
        end
        if (r_state == S_SQR && sqr_done) begin
            r_diff <= w_diff;
        end
        if (r_state == S_CHK) begin
            r_ok <= w_ok;
        end
        if (out_load) begin
            r_out_root  <= r_guess;
            r_out_conv  <= r_ok;
            r_out_steps <= r_steps;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_root        = r_out_root;
    assign o_converged   = r_out_conv;
    assign o_steps_taken = 7'(r_out_steps);

    // a result never reports zero steps
    a_steps_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_steps_taken != 7'd0)
        else $error("result with zero steps");

    // not converged only when the cap was reached
    a_cap_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_converged) |-> o_steps_taken == 7'(MAX_STEPS))
        else $error("unconverged result below step cap");

    // divider never runs on a zero divisor
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_gstep != '0)
        else $error("division by zero guess");

    // units report completion only in their own phase
    a_div_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider done outside divide phase");

    a_sqr_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqr_done |-> r_state == S_SQR)
        else $error("squarer done outside square phase");

endmodule

`default_nettype wire

// ===== tb/tb_newton_square_root_warm_start.sv =====
// ----------------------------------------------------------------------------
// tb_newton_square_root_warm_start - self-checking bench for the Newton root
// Drives radicand beats through the valid/ready input, predicts every root
// from a bit-accurate Newton model that carries its own kept guess and
// tolerance, and checks each output beat field by field. A directed table
// covers the extremes and corner cases; random phases at several tolerance
// settings follow, with random idling on both sides and two long sink stalls.
// ----------------------------------------------------------------------------

module tb_newton_square_root_warm_start;

    import nsqrt_pkg::*;

    // one Newton step in the block: divider + squarer + set-up and check
    localparam int STEP_CYCLES = NUM_BITS + VALUE_BITS + 5;
    // after the last root arrives, keep watching for stray beats
    localparam int DRAIN_CYCLES = 2 * STEP_CYCLES;
    // slowest legal run: 1160 beats, each capped at 64 steps, plus the longest
    // sender gap and sink stall per beat, with margin on top
    localparam int LIMIT_CYCLES = 50_000_000;
    // sink hold-off long enough for the block to fill and block its input
    localparam int HOLD_CYCLES = 4000;

    typedef struct packed {
        logic [VALUE_BITS-1:0] root;
        logic                  converged;
        logic [6:0]            steps;
    } t_root_result;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_TOL
    } t_row_kind;

    typedef struct packed {
        t_row_kind    kind;
        logic [31:0]  value;
        logic         typed;
        t_root_result want;
    } t_stim_row;

    // sqrt(4) from the reset guess of 2.0 is exact after one step
    localparam t_root_result ROOT_OF_FOUR = {TWO_POINT_ZERO, 1'b1, 7'd1};

    // ------------------------------------------------------------------------
    // DUT signals; every input known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [31:0]           i_cfg_wr_data = '0;
    logic                  i_valid       = 1'b0;
    logic                  o_ready;
    logic [INPUT_BITS-1:0] i_radicand    = '0;
    logic                  o_valid;
    logic                  i_ready       = 1'b0;
    logic [VALUE_BITS-1:0] o_root;
    logic                  o_converged;
    logic [6:0]            o_steps_taken;

    newton_square_root_warm_start u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_radicand    (i_radicand),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_root        (o_root),
        .o_converged   (o_converged),
        .o_steps_taken (o_steps_taken)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Model state and bookkeeping
    // ------------------------------------------------------------------------
    logic [VALUE_BITS-1:0] kept_guess    = TWO_POINT_ZERO;
    logic [31:0]           cur_tolerance = TOL_RESET;
    t_root_result          pending_roots[$];
    t_stim_row             directed_rows[$];
    logic [INPUT_BITS-1:0] last_radicand = '0;

    int mismatches      = 0;
    int radicands_sent  = 0;
    int roots_checked   = 0;
    int capped_roots    = 0;
    int tol_writes      = 0;
    int calm_beats      = 0;
    longint cycle_count = 0;

    // sink pacing state
    int stall_left = 0;
    int gap_left   = 0;
    int calm_left  = 0;

    // ------------------------------------------------------------------------
    // Root predictor. Numerator is x << 2F, so x/g comes out with F fraction
    // bits; quotient saturates at the 52-bit all-ones. Residual compares
    // x << F against y*y truncated to F fraction bits, strictly below tol.
    // ------------------------------------------------------------------------
    function automatic t_root_result predict_root(input logic [INPUT_BITS-1:0] x);
        logic [127:0]          num;
        logic [127:0]          quo;
        logic [127:0]          lhs;
        logic [127:0]          sq;
        logic [127:0]          diff;
        logic [VALUE_BITS-1:0] g;
        logic [VALUE_BITS-1:0] q;
        logic                  done;
        int                    n;
        t_root_result          res;
        num  = 128'(x) << (2 * FRACTION_BITS);
        lhs  = 128'(x) << FRACTION_BITS;
        g    = kept_guess;
        done = 1'b0;
        n    = 0;
        // at least one step, even when the kept guess already fits
        while (!done && n < MAX_STEPS) begin
            if (g == '0)
                g = TWO_POINT_ZERO;
            quo = num / 128'(g);
            q   = (quo[127:VALUE_BITS] != '0) ? '1 : quo[VALUE_BITS-1:0];
            // halve both terms, keep the carry of the two dropped lsbs
            g   = (q >> 1) + (g >> 1) + (q[0] & g[0]);
            n++;
            sq   = (128'(g) * 128'(g)) >> FRACTION_BITS;
            diff = (lhs >= sq) ? lhs - sq : sq - lhs;
            done = (diff < 128'(cur_tolerance));
        end
        kept_guess    = g;
        res.root      = g;
        res.converged = done;
        res.steps     = 7'(n);
        return res;
    endfunction

    function automatic void add_row(input t_row_kind kind, input logic [31:0] value,
                                    input logic typed, input t_root_result want);
        t_stim_row row;
        row.kind  = kind;
        row.value = value;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // sender idling: mostly back to back, some short gaps, a few long ones,
    // and now and then a calm run of beats with no gaps at all
    function automatic int sender_gap();
        int r;
        if (calm_beats > 0) begin
            calm_beats--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm_beats = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 6);
        if (r < 97)
            return $urandom_range(7, 60);
        return $urandom_range(150, 600);
    endfunction

    // random radicands: often close to the last one so the warm start pays
    // off in a step or two, plus full-range jumps, small values, extremes, sparse and dense bits
    function automatic logic [INPUT_BITS-1:0] pick_radicand();
        int                    r;
        logic [INPUT_BITS-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            v = last_radicand + INPUT_BITS'($urandom_range(0, 32)) - INPUT_BITS'(16);
        end else if (r < 70) begin
            v = INPUT_BITS'($urandom);
        end else if (r < 85) begin
            v = INPUT_BITS'($urandom_range(0, 255));
        end else if (r < 93) begin
            case ($urandom_range(0, 3))
                0: v = '0;
                1: v = '1;
                2: v = INPUT_BITS'(1);
                default: v = INPUT_BITS'(1) << $urandom_range(0, INPUT_BITS - 1);
            endcase
        end else if (r < 97) begin
            v = INPUT_BITS'($urandom & $urandom);
        end else begin
            v = INPUT_BITS'($urandom | $urandom);
        end
        return v;
    endfunction

    // one radicand beat; valid stays up across back-to-back beats
    task automatic send_radicand(input logic [INPUT_BITS-1:0] x, input logic typed,
                                 input t_root_result want);
        t_root_result pred;
        int           gap;
        i_valid    <= 1'b1;
        i_radicand <= x;
        do
            @(posedge i_clk);
        while (!o_ready);
        // model state advances even where the expected root is typed in
        pred = predict_root(x);
        pending_roots.push_back(typed ? want : pred);
        radicands_sent++;
        last_radicand = x;
        gap = sender_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drop valid and wait for every outstanding root to come back
    task automatic drain_roots();
        i_valid <= 1'b0;
        while (pending_roots.size() != 0)
            @(posedge i_clk);
    endtask

    // tolerance is only written with the block idle
    task automatic write_tolerance(input logic [31:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_tolerance = value;
        tol_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: check each output beat, then pick next cycle's ready
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : root_sink
        t_root_result want;
        int           r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_roots.size() == 0) begin
                $error("root beat with nothing pending: root %h", o_root);
                mismatches++;
            end else begin
                want = pending_roots.pop_front();
                if (o_root !== want.root) begin
                    $error("root: expected %h, got %h", want.root, o_root);
                    mismatches++;
                end
                if (o_converged !== want.converged) begin
                    $error("converged: expected %0b, got %0b", want.converged, o_converged);
                    mismatches++;
                end
                if (o_steps_taken !== want.steps) begin
                    $error("steps_taken: expected %0d, got %0d", want.steps, o_steps_taken);
                    mismatches++;
                end
                if (!want.converged)
                    capped_roots++;
            end
            roots_checked++;
            // long hold-off twice in the run: sender keeps offering, so the
            // output register and the finished core both fill and o_ready drops
            if (roots_checked == 300 || roots_checked == 800)
                stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            i_ready <= 1'b0;
        end else if (calm_left > 0) begin
            calm_left--;
            i_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 999);
            if (r < 5) begin
                calm_left = $urandom_range(200, 2000);
                i_ready <= 1'b1;
            end else if (r < 80) begin
                gap_left = $urandom_range(0, 3);
                i_ready <= 1'b0;
            end else if (r < 86) begin
                gap_left = $urandom_range(20, 300);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("watchdog expired after %0d cycles, %0d roots pending",
                     cycle_count, pending_roots.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_stim_row   row;
        logic [31:0] tol;
        int          beats;

        // directed table, reset tolerance first
        add_row(ROW_ITEM, 32'd4,       1'b1, ROOT_OF_FOUR);  // exact from reset guess
        add_row(ROW_ITEM, 32'd4,       1'b1, ROOT_OF_FOUR);  // fits already, still one step
        add_row(ROW_ITEM, 32'hFFFFF,   1'b0, '0);            // largest radicand
        add_row(ROW_ITEM, 32'd0,       1'b0, '0);            // zero: guess only halves
        add_row(ROW_ITEM, 32'hFFFFF,   1'b0, '0);            // tiny guess, quotient saturates
        add_row(ROW_ITEM, 32'd1,       1'b0, '0);
        add_row(ROW_ITEM, 32'hAAAAA,   1'b0, '0);
        add_row(ROW_ITEM, 32'h55555,   1'b0, '0);
        add_row(ROW_ITEM, 32'h80000,   1'b0, '0);
        add_row(ROW_ITEM, 32'd2,       1'b0, '0);
        // zero tolerance is never met: every beat runs to the cap
        add_row(ROW_TOL,  32'd0,       1'b0, '0);
        add_row(ROW_ITEM, 32'd0,       1'b0, '0);            // guess halves to zero, reloads 2.0
        add_row(ROW_ITEM, 32'd16,      1'b0, '0);            // near-zero guess, saturation again
        // loosest tolerance
        add_row(ROW_TOL,  32'hFFFFFFFF, 1'b0, '0);
        add_row(ROW_ITEM, 32'hFFFFF,   1'b0, '0);
        add_row(ROW_ITEM, 32'd3,       1'b0, '0);
        add_row(ROW_ITEM, 32'd0,       1'b0, '0);
        // one lsb: exact residual needed
        add_row(ROW_TOL,  32'd1,       1'b0, '0);
        add_row(ROW_ITEM, 32'd100,     1'b0, '0);
        add_row(ROW_ITEM, 32'd99,      1'b0, '0);
        add_row(ROW_TOL,  TOL_RESET,   1'b0, '0);
        add_row(ROW_ITEM, 32'd1000,    1'b0, '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < directed_rows.size(); k++) begin
            row = directed_rows[k];
            if (row.kind == ROW_TOL) begin
                drain_roots();
                write_tolerance(row.value);
            end else begin
                send_radicand(row.value[INPUT_BITS-1:0], row.typed, row.want);
            end
        end

        // random phases; the tight tolerances only get a handful of beats
        // since most of those run the full 64 steps
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin tol = TOL_RESET;                  beats = 230; end
                1: begin tol = 32'hFFFFFFFF;               beats = 200; end
                2: begin tol = $urandom;                   beats = 200; end
                3: begin tol = 32'd0;                      beats = 6;   end
                4: begin tol = $urandom_range(1 << 14, 1 << 24); beats = 200; end
                5: begin tol = 32'd1;                      beats = 6;   end
                6: begin tol = $urandom;                   beats = 150; end
                default: begin tol = TOL_RESET;            beats = 150; end
            endcase
            drain_roots();
            write_tolerance(tol);
            repeat (beats)
                send_radicand(pick_radicand(), 1'b0, '0);
        end

        drain_roots();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d radicands over %0d tolerance settings, %0d roots checked",
                 radicands_sent, tol_writes, roots_checked);
        $display("%0d roots ended at the step cap, %0d mismatches", capped_roots, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
